// ===== design/rbb_pkg.sv =====
// Shared types and constants of the RGB 5x5 box blur.
package rbb_pkg;

   localparam int CHAN_W      = 8;
   localparam int ROW_W       = 12;
   localparam int OUT_COL_W   = 10;
   localparam int COLSUM_W    = 11;
   localparam int SUM_W       = 13;
   localparam int WIN         = 5;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_CAP   = 13'd4096;

   // floor(x / 25) == (x * 5243) >> 17 for every x below 43690
   localparam logic [12:0] DIV_MUL   = 13'd5243;
   localparam int          DIV_SHIFT = 17;
   localparam int          PROD_W    = SUM_W + 13;

   // 25 * 255, and 15 * 255 for a centre on the top row
   localparam logic [SUM_W-1:0] SUM_MAX          = 13'd6375;
   localparam logic [SUM_W-1:0] EDGE_ROW_SUM_MAX = 13'd3825;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1
   } csr_reg_type;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   // centre offset inside the window, 0..2
   typedef logic [1:0] offset_type;

   // suffix sums of one window column: [i] = sum of window rows i..4
   typedef struct packed {
      logic [2:0][COLSUM_W-1:0] red;
      logic [2:0][COLSUM_W-1:0] green;
      logic [2:0][COLSUM_W-1:0] blue;
   } colsum_type;

   // centres a request completes: row offsets i_min..i_max, column offsets j_min..j_max
   typedef struct packed {
      offset_type             i_min;
      offset_type             i_max;
      offset_type             j_min;
      offset_type             j_max;
      logic [ROW_W-1:0]       row;
      logic [OUT_COL_W-1:0]   col;
   } job_type;

   typedef struct packed {
      logic [SUM_W-1:0]     red;
      logic [SUM_W-1:0]     green;
      logic [SUM_W-1:0]     blue;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } sum_type;

endpackage

// ===== design/rgb_box_blur_5x5_core.sv =====
// RGB 5x5 box blur core: streaming mean filter over a raster-order frame.
// A request passes stage 1, the window sequencer, the sum register and the result register.
// Throughput: one request per cycle; a request that completes n > 1 windows (last column
//   or last row, up to 9) holds req_ready low while the centre sequencer emits one result
//   per cycle, and a low rsp_ready stalls both. Reset: synchronous, active high; clears all
//   handshake state and positions, sets both frame registers to 1024; no clearing pass.
module rgb_box_blur_5x5_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel requests
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rbb_pkg::chan_type                  req_red_in,
   input  rbb_pkg::chan_type                  req_green_in,
   input  rbb_pkg::chan_type                  req_blue_in,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rbb_pkg::chan_type                  rsp_red_out,
   output rbb_pkg::chan_type                  rsp_green_out,
   output rbb_pkg::chan_type                  rsp_blue_out,
   output logic [rbb_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [rbb_pkg::OUT_COL_W-1:0]      rsp_out_col,
   output logic                               rsp_last_of_run,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rbb_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int XW     = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
   localparam int LINE_W = 4 * $bits(pixel_type);

   // configuration
   logic [WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic                csr_fire, csr_restart;
   logic [XW-1:0]       fw_x;
   logic [CW-1:0]       w_m1;
   logic [ROW_W-1:0]    h_m1;

   // position of the next request
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                accept;

   // stage 1: accepted pixel, line store data arrives here
   logic                s1_valid_ff, s1_valid_in;
   pixel_type           s1_px_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic                byp_ff;
   pixel_type [3:0]     byp_data_ff;
   logic                byp_in;

   logic [LINE_W-1:0]   ram_rd_raw;
   pixel_type [3:0]     line_rd, line_px, line_wr;
   pixel_type [WIN-1:0] win_px;
   logic                line_we, load_ready, load_fire;
   job_type             job;

   sum_type             sum_data;
   logic                sum_valid, sum_ready;

   //------------------------------------------------------------------
   // Configuration port. A write to a known register restarts the frame.
   //------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      csr_restart     = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[WIDTH_W-1:0];
               csr_restart    = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[HEIGHT_W-1:0];
               csr_restart     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // effective width - 1: zero counts as 1, capped at MAX_WIDTH
   always_comb begin
      fw_x = XW'(frame_width_ff);
      if (frame_width_ff == '0) begin
         w_m1 = '0;
      end else if (fw_x > XW'(MAX_WIDTH)) begin
         w_m1 = CW'(MAX_WIDTH - 1);
      end else begin
         w_m1 = CW'(fw_x - XW'(1));
      end
   end

   // effective height - 1: zero counts as 1, capped at 4096
   always_comb begin
      if (frame_height_ff == '0) begin
         h_m1 = '0;
      end else if (frame_height_ff > HEIGHT_CAP) begin
         h_m1 = ROW_W'(HEIGHT_CAP - 13'd1);
      end else begin
         h_m1 = ROW_W'(frame_height_ff - 13'd1);
      end
   end

   //------------------------------------------------------------------
   // Request acceptance and raster position.
   //------------------------------------------------------------------
   assign load_fire = s1_valid_ff && load_ready;
   assign req_ready = !s1_valid_ff || load_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_m1) begin
            col_in = '0;
            row_in = (row_ff == h_m1) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (load_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // A one-column frame reads the column that stage 1 writes in the same edge;
   // the RAM is read-first, so that word is forwarded.
   assign byp_in = line_we && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= {req_red_in, req_green_in, req_blue_in};
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         byp_ff      <= byp_in;
         byp_data_ff <= line_wr;
      end
   end

   //------------------------------------------------------------------
   // Line store: per column the four rows above the current one.
   //------------------------------------------------------------------
   assign line_we = load_fire;

   rbb_ram #(
      .WIDTH(LINE_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (line_we),
      .wr_addr(s1_col_ff),
      .wr_data(line_wr),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(ram_rd_raw)
   );

   assign line_rd = ram_rd_raw;
   assign line_px = byp_ff ? byp_data_ff : line_rd;

   // new window column: rows above the frame read as zero, the pixel goes last
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         win_px[k] = (s1_row_ff < ROW_W'(4 - k)) ? '0 : line_px[k];
      end
      win_px[WIN-1] = s1_px_ff;
      for (int k = 0; k < 4; k++) begin
         line_wr[k] = win_px[k + 1];
      end
   end

   // Centres this pixel completes: row r-2 always, rows r-1 and r too on the
   // last row; likewise for columns. Centres above or left of the frame drop.
   always_comb begin
      if (s1_row_ff >= ROW_W'(2)) begin
         job.i_min = 2'd0;
      end else if (s1_row_ff == ROW_W'(1)) begin
         job.i_min = 2'd1;
      end else begin
         job.i_min = 2'd2;
      end
      job.i_max = (s1_row_ff == h_m1) ? 2'd2 : 2'd0;
      if (s1_col_ff >= CW'(2)) begin
         job.j_min = 2'd0;
      end else if (s1_col_ff == CW'(1)) begin
         job.j_min = 2'd1;
      end else begin
         job.j_min = 2'd2;
      end
      job.j_max = (s1_col_ff == w_m1) ? 2'd2 : 2'd0;
      job.row   = s1_row_ff;
      job.col   = OUT_COL_W'(s1_col_ff);
   end

   //------------------------------------------------------------------
   // Column sums and centre sequencer, then divide and result register.
   //------------------------------------------------------------------
   rbb_window u_window (
      .clock     (clock),
      .reset     (reset),
      .load_valid(s1_valid_ff),
      .load_ready(load_ready),
      .load_clear(s1_col_ff == '0),
      .load_px   (win_px),
      .load_job  (job),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum_data  (sum_data)
   );

   rbb_mean u_mean (
      .clock          (clock),
      .reset          (reset),
      .sum_valid      (sum_valid),
      .sum_ready      (sum_ready),
      .sum_data       (sum_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_last_of_run(rsp_last_of_run)
   );

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   // a window sum never exceeds 25 full-scale values
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_valid |-> (sum_data.red <= SUM_MAX) && (sum_data.green <= SUM_MAX) &&
                    (sum_data.blue <= SUM_MAX))
      else $error("window sum out of range");

   // a top-row centre sees at most three rows: masking above the frame works
   a_top_row: assert property (@(posedge clock) disable iff (reset)
      sum_valid && (sum_data.row == '0) |->
         (sum_data.red <= EDGE_ROW_SUM_MAX) && (sum_data.green <= EDGE_ROW_SUM_MAX) &&
         (sum_data.blue <= EDGE_ROW_SUM_MAX))
      else $error("rows above the frame leaked into a sum");

   // while a result that is not the last of its run waits, its successor is queued
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> sum_valid)
      else $error("run of results broken");

endmodule

// ===== design/rbb_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
module rbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-first: a same-edge write is not seen
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rbb_window.sv =====
// Window column sums and the sequencer that walks the centres of one request.
module rbb_window (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_valid,
   output logic                                 load_ready,
   input  logic                                 load_clear,
   input  rbb_pkg::pixel_type [rbb_pkg::WIN-1:0] load_px,
   input  rbb_pkg::job_type                     load_job,
   output logic                                 sum_valid,
   input  logic                                 sum_ready,
   output rbb_pkg::sum_type                     sum_data
);
   import rbb_pkg::*;

   colsum_type [WIN-1:0] col_ff, col_in;
   colsum_type           new_col;
   job_type              job_ff, job_in;
   offset_type           cur_i_ff, cur_i_in;
   offset_type           cur_j_ff, cur_j_in;
   logic                 active_ff, active_in;
   logic                 sum_valid_ff, sum_valid_in;
   sum_type              sum_ff, sum_in;
   logic [SUM_W-1:0]     red_acc, green_acc, blue_acc;
   logic                 m_ready, emit, is_last, load;

   assign is_last    = (cur_i_ff == job_ff.i_max) && (cur_j_ff == job_ff.j_max);
   assign m_ready    = !sum_valid_ff || sum_ready;
   assign emit       = active_ff && m_ready;
   assign load_ready = !active_ff || (m_ready && is_last);
   assign load       = load_valid && load_ready;

   // suffix sums of the incoming column
   always_comb begin
      new_col = '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < WIN; k++) begin
            if (k >= i) begin
               new_col.red[i]   = new_col.red[i]   + COLSUM_W'(load_px[k].red);
               new_col.green[i] = new_col.green[i] + COLSUM_W'(load_px[k].green);
               new_col.blue[i]  = new_col.blue[i]  + COLSUM_W'(load_px[k].blue);
            end
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      if (load) begin
         for (int wc = 0; wc < WIN - 1; wc++) begin
            col_in[wc] = load_clear ? '0 : col_ff[wc + 1];
         end
         col_in[WIN-1] = new_col;
      end
   end

   // window sum for centre (cur_i, cur_j): columns cur_j..4 of row suffix cur_i
   always_comb begin
      red_acc   = '0;
      green_acc = '0;
      blue_acc  = '0;
      for (int wc = 0; wc < WIN; wc++) begin
         if (wc >= int'(cur_j_ff)) begin
            red_acc   = red_acc   + SUM_W'(col_ff[wc].red[cur_i_ff]);
            green_acc = green_acc + SUM_W'(col_ff[wc].green[cur_i_ff]);
            blue_acc  = blue_acc  + SUM_W'(col_ff[wc].blue[cur_i_ff]);
         end
      end
      sum_in.red   = red_acc;
      sum_in.green = green_acc;
      sum_in.blue  = blue_acc;
      sum_in.row   = job_ff.row + ROW_W'(cur_i_ff) - ROW_W'(2);
      sum_in.col   = job_ff.col + OUT_COL_W'(cur_j_ff) - OUT_COL_W'(2);
      sum_in.last  = is_last;
   end

   always_comb begin
      job_in    = job_ff;
      active_in = active_ff;
      cur_i_in  = cur_i_ff;
      cur_j_in  = cur_j_ff;
      if (load) begin
         job_in    = load_job;
         active_in = (load_job.i_min <= load_job.i_max) && (load_job.j_min <= load_job.j_max);
         cur_i_in  = load_job.i_min;
         cur_j_in  = load_job.j_min;
      end else if (emit) begin
         if (is_last) begin
            active_in = 1'b0;
         end else if (cur_j_ff == job_ff.j_max) begin
            cur_j_in = job_ff.j_min;
            cur_i_in = cur_i_ff + 2'd1;
         end else begin
            cur_j_in = cur_j_ff + 2'd1;
         end
      end
   end

   always_comb begin
      if (emit) begin
         sum_valid_in = 1'b1;
      end else if (sum_ready) begin
         sum_valid_in = 1'b0;
      end else begin
         sum_valid_in = sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      job_ff   <= job_in;
      cur_i_ff <= cur_i_in;
      cur_j_ff <= cur_j_in;
      if (emit) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum_data  = sum_ff;

endmodule

// ===== design/rbb_mean.sv =====
// Divide-by-25 stage and result register.
module rbb_mean (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sum_valid,
   output logic                              sum_ready,
   input  rbb_pkg::sum_type                  sum_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rbb_pkg::chan_type                 rsp_red_out,
   output rbb_pkg::chan_type                 rsp_green_out,
   output rbb_pkg::chan_type                 rsp_blue_out,
   output logic [rbb_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [rbb_pkg::OUT_COL_W-1:0]     rsp_out_col,
   output logic                              rsp_last_of_run
);
   import rbb_pkg::*;

   logic                 valid_ff, valid_in;
   chan_type             red_ff, green_ff, blue_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [OUT_COL_W-1:0] col_ff;
   logic                 last_ff;
   logic                 take;

   function automatic chan_type div25(input logic [SUM_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(DIV_MUL);
      return chan_type'(prod >> DIV_SHIFT);
   endfunction

   assign sum_ready = !valid_ff || rsp_ready;
   assign take      = sum_valid && sum_ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         red_ff   <= div25(sum_data.red);
         green_ff <= div25(sum_data.green);
         blue_ff  <= div25(sum_data.blue);
         row_ff   <= sum_data.row;
         col_ff   <= sum_data.col;
         last_ff  <= sum_data.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_red_out     = red_ff;
   assign rsp_green_out   = green_ff;
   assign rsp_blue_out    = blue_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_last_of_run = last_ff;

endmodule
